>>> rtl/ceat_pkg.sv
`default_nettype none
package ceat_pkg;

  localparam int unsigned HYS_MUL = 328;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_ACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_HIGH = 2'd0,
    KIND_LOW  = 2'd1,
    KIND_COMM = 2'd2,
    KIND_OPEN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    COND_MEAS    = 2'd0,
    COND_COMM    = 2'd1,
    COND_OPEN    = 2'd2,
    COND_INVALID = 2'd3
  } cond_e;

  typedef enum logic [1:0] {
    LV_NORMAL = 2'd0,
    LV_HIGH   = 2'd1,
    LV_LOW    = 2'd2
  } level_e;

  typedef enum logic [1:0] {
    CLS_ACK    = 2'd0,
    CLS_IGNORE = 2'd1,
    CLS_EVAL   = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EVAL  = 2'd1,
    ST_EMIT1 = 2'd2,
    ST_EMIT2 = 2'd3
  } state_e;

  typedef struct packed {
    class_e             cls;
    logic [3:0]         channel;
    cond_e              cond;
    logic signed [31:0] value;
    logic signed [31:0] alarm_high;
    logic signed [31:0] alarm_low;
    logic signed [26:0] hys;
  } item_t;

  typedef struct packed {
    action_e            action;
    logic [3:0]         channel;
    kind_e              kind;
    logic signed [31:0] value;
    logic [5:0]         acked_now;
    logic [4:0]         active;
    logic [5:0]         unacked;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/ceat_ram.sv
`default_nettype none
module ceat_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/ceat_front.sv
`default_nettype none
module ceat_front #(
  parameter int CHANNELS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [3:0]         channel_i,
  input  wire logic [1:0]         condition_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] alarm_high_i,
  input  wire logic signed [31:0] alarm_low_i,
  input  wire logic signed [31:0] range_high_i,
  input  wire logic signed [31:0] range_low_i,
  output logic                    item_valid_o,
  output ceat_pkg::item_t         item_o,
  input  wire logic               pop_i
);

  localparam logic signed [42:0] HysMul = 43'(ceat_pkg::HYS_MUL);

  logic signed [32:0] span;
  logic signed [42:0] prod;
  ceat_pkg::item_t    item_in;
  ceat_pkg::item_t    slot_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push, pop;

  always_comb begin
    span = 33'(range_high_i) - 33'(range_low_i);
    prod = 43'(span) * HysMul;
    item_in.channel    = channel_i;
    item_in.cond       = ceat_pkg::cond_e'(condition_i);
    item_in.value      = value_i;
    item_in.alarm_high = alarm_high_i;
    item_in.alarm_low  = alarm_low_i;
    item_in.hys        = prod[42:16];
    if (mode_i) begin
      item_in.cls = ceat_pkg::CLS_ACK;
    end else if (32'(channel_i) < CHANNELS) begin
      item_in.cls = ceat_pkg::CLS_EVAL;
    end else begin
      item_in.cls = ceat_pkg::CLS_IGNORE;
    end
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ceat_back.sv
`default_nettype none
module ceat_back #(
  parameter int CHANNELS      = 16,
  parameter int HISTORY_DEPTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  wire ceat_pkg::item_t  item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ceat_pkg::result_t     res_o
);

  localparam int NCH = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int ACW = $clog2(NCH + 1);
  localparam int UCW = $clog2(HISTORY_DEPTH + 1);

  ceat_pkg::state_e   state_q, state_d;
  ceat_pkg::item_t    it_q;
  ceat_pkg::level_e   level_q [NCH];
  logic [AW-1:0]      open_q [NCH];
  logic [NCH-1:0]     open_v_q, open_v_d;
  logic [HISTORY_DEPTH-1:0] ack_q, clr_q, del_q;
  logic [AW-1:0]      wp_q;
  logic [UCW-1:0]     fill_q;
  logic [ACW-1:0]     active_q, active_d;
  logic [UCW-1:0]     unacked_q, unacked_d;
  ceat_pkg::result_t  r0_q, r1_q, r0_d, r1_d, clr_r, set_r, none_r;
  logic               two_q;
  logic               out_free;

  logic [33:0]        rdata;
  logic [CW-1:0]      ci;
  logic               ov;
  ceat_pkg::kind_e    okind;
  ceat_pkg::level_e   lv, ns, lv_d;
  logic [AW-1:0]      slot_c;
  logic               do_clr, do_set;
  ceat_pkg::kind_e    set_kind, fkind;
  logic signed [31:0] set_val;
  logic signed [33:0] v34, ahi_m, alo_p;
  logic [NCH-1:0]     v1, v2, match;
  logic               drop, counted;

  assign out_free = !out_valid_o || !out_stall_i;
  assign pop_o    = (state_q == ceat_pkg::ST_IDLE) && item_valid_i;

  ceat_ram #(.WIDTH(34), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i  (clk_i),
    .we_i   ((state_q == ceat_pkg::ST_EVAL) && do_set),
    .waddr_i(wp_q),
    .wdata_i({set_kind, set_val}),
    .raddr_i(open_q[item_i.channel[CW-1:0]]),
    .rdata_o(rdata)
  );

  always_comb begin
    ci     = it_q.channel[CW-1:0];
    ov     = open_v_q[ci];
    okind  = ceat_pkg::kind_e'(rdata[33:32]);
    lv     = level_q[ci];
    slot_c = open_q[ci];
    v34    = 34'(it_q.value);
    ahi_m  = 34'(it_q.alarm_high) - 34'(it_q.hys);
    alo_p  = 34'(it_q.alarm_low) + 34'(it_q.hys);
    do_clr   = 1'b0;
    do_set   = 1'b0;
    set_kind = ceat_pkg::KIND_HIGH;
    set_val  = '0;
    lv_d     = ceat_pkg::LV_NORMAL;
    ns       = ceat_pkg::LV_NORMAL;
    fkind    = (it_q.cond == ceat_pkg::COND_OPEN) ? ceat_pkg::KIND_OPEN : ceat_pkg::KIND_COMM;
    unique case (it_q.cond)
      ceat_pkg::COND_COMM, ceat_pkg::COND_OPEN: begin
        if (!ov || okind != fkind) begin
          do_clr   = ov;
          do_set   = 1'b1;
          set_kind = fkind;
        end
      end
      ceat_pkg::COND_INVALID: begin
        do_clr = ov;
      end
      ceat_pkg::COND_MEAS: begin
        if (v34 > 34'(it_q.alarm_high)) ns = ceat_pkg::LV_HIGH;
        else if (v34 < 34'(it_q.alarm_low)) ns = ceat_pkg::LV_LOW;
        else if (lv == ceat_pkg::LV_HIGH && v34 > ahi_m) ns = ceat_pkg::LV_HIGH;
        else if (lv == ceat_pkg::LV_LOW && v34 < alo_p) ns = ceat_pkg::LV_LOW;
        lv_d   = ns;
        do_clr = ov && okind[1];
        if (ns != lv) begin
          if (ns == ceat_pkg::LV_NORMAL) begin
            do_clr = ov;
          end else begin
            do_set   = 1'b1;
            set_kind = (ns == ceat_pkg::LV_HIGH) ? ceat_pkg::KIND_HIGH : ceat_pkg::KIND_LOW;
            set_val  = it_q.value;
          end
        end
      end
      default: ;
    endcase

    v1 = open_v_q;
    if (do_clr) v1[ci] = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      match[i] = v1[i] && (open_q[i] == wp_q);
    end
    drop = |match;
    v2   = v1 & ~match;
    open_v_d = v1;
    active_d = active_q - ACW'(do_clr);
    if (do_set) begin
      open_v_d     = v2;
      open_v_d[ci] = 1'b1;
      active_d     = active_d - ACW'(drop) + ACW'(!v2[ci]);
    end
    counted   = (fill_q == UCW'(HISTORY_DEPTH)) && !ack_q[wp_q] && !del_q[wp_q];
    unacked_d = (do_set && !counted) ? unacked_q + UCW'(1) : unacked_q;

    clr_r.action    = ceat_pkg::ACT_CLEAR;
    clr_r.channel   = it_q.channel;
    clr_r.kind      = okind;
    clr_r.value     = rdata[31:0];
    clr_r.acked_now = '0;
    clr_r.active    = 5'(active_d);
    clr_r.unacked   = 6'(unacked_d);
    clr_r.last      = !do_set;
    set_r           = clr_r;
    set_r.action    = ceat_pkg::ACT_SET;
    set_r.kind      = set_kind;
    set_r.value     = set_val;
    set_r.last      = 1'b1;
    none_r          = clr_r;
    none_r.action   = ceat_pkg::ACT_NONE;
    none_r.kind     = ceat_pkg::KIND_HIGH;
    none_r.value    = '0;
    none_r.last     = 1'b1;
    r0_d = do_clr ? clr_r : (do_set ? set_r : none_r);
    r1_d = set_r;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ceat_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          state_d = (item_i.cls == ceat_pkg::CLS_EVAL) ? ceat_pkg::ST_EVAL : ceat_pkg::ST_EMIT1;
        end
      end
      ceat_pkg::ST_EVAL:  state_d = ceat_pkg::ST_EMIT1;
      ceat_pkg::ST_EMIT1: begin
        if (out_free) state_d = two_q ? ceat_pkg::ST_EMIT2 : ceat_pkg::ST_IDLE;
      end
      ceat_pkg::ST_EMIT2: begin
        if (out_free) state_d = ceat_pkg::ST_IDLE;
      end
      default: state_d = ceat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ceat_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q                <= item_i;
      r0_q.action         <= (item_i.cls == ceat_pkg::CLS_ACK) ? ceat_pkg::ACT_ACK
                                                                 : ceat_pkg::ACT_NONE;
      r0_q.channel        <= (item_i.cls == ceat_pkg::CLS_ACK) ? 4'd0 : item_i.channel;
      r0_q.kind           <= ceat_pkg::KIND_HIGH;
      r0_q.value          <= '0;
      r0_q.acked_now      <= (item_i.cls == ceat_pkg::CLS_ACK) ? 6'(unacked_q) : 6'd0;
      r0_q.active         <= 5'(active_q);
      r0_q.unacked        <= (item_i.cls == ceat_pkg::CLS_ACK) ? 6'd0 : 6'(unacked_q);
      r0_q.last           <= 1'b1;
    end else if (state_q == ceat_pkg::ST_EVAL) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
    end
    if (out_free && state_q == ceat_pkg::ST_EMIT1) res_o <= r0_q;
    else if (out_free && state_q == ceat_pkg::ST_EMIT2) res_o <= r1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        level_q[i] <= ceat_pkg::LV_NORMAL;
        open_q[i]  <= '0;
      end
      open_v_q    <= '0;
      ack_q       <= '0;
      clr_q       <= '0;
      del_q       <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      active_q    <= '0;
      unacked_q   <= '0;
      two_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_o <= (state_q == ceat_pkg::ST_EMIT1) || (state_q == ceat_pkg::ST_EMIT2);
      end
      if (pop_o) begin
        two_q <= 1'b0;
        if (item_i.cls == ceat_pkg::CLS_ACK) begin
          unacked_q <= '0;
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (UCW'(i) < fill_q) begin
              ack_q[i] <= 1'b1;
              if (clr_q[i]) del_q[i] <= 1'b1;
            end
          end
        end
      end else if (state_q == ceat_pkg::ST_EVAL) begin
        two_q       <= do_clr && do_set;
        level_q[ci] <= lv_d;
        open_v_q    <= open_v_d;
        active_q    <= active_d;
        unacked_q   <= unacked_d;
        if (do_clr) begin
          clr_q[slot_c] <= 1'b1;
          if (ack_q[slot_c]) del_q[slot_c] <= 1'b1;
        end
        if (do_set) begin
          ack_q[wp_q] <= 1'b0;
          clr_q[wp_q] <= 1'b0;
          del_q[wp_q] <= 1'b0;
          open_q[ci]  <= wp_q;
          wp_q        <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
          if (fill_q < UCW'(HISTORY_DEPTH)) fill_q <= fill_q + UCW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/channel_alarm_event_tracker_unit.sv
// A 2-entry queue feeds the single back-end sequencer. A reading is evaluated
// with its history entry in ST_EVAL before its first result in ST_EMIT1;
// acknowledge-all and ignored items skip ST_EVAL, and a second result follows in
// ST_EMIT2. The sequencer pops only in ST_IDLE and waits on an output stall.
// Reset clears levels, open references, entry marks, pointer and counts at once;
// history payload is undefined until written, so no clearing pass is needed.
`default_nettype none
module channel_alarm_event_tracker_unit #(
  parameter int CHANNELS      = 16,
  parameter int HISTORY_DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [3:0]         channel_i,
  input  wire logic [1:0]         condition_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] alarm_high_i,
  input  wire logic signed [31:0] alarm_low_i,
  input  wire logic signed [31:0] range_high_i,
  input  wire logic signed [31:0] range_low_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              action_o,
  output logic [3:0]              event_channel_o,
  output logic [1:0]              alarm_kind_o,
  output logic signed [31:0]      event_value_o,
  output logic [5:0]              acked_now_o,
  output logic [4:0]              active_alarms_o,
  output logic [5:0]              unacked_alarms_o,
  output logic                    last_o
);

  ceat_pkg::item_t   item;
  logic              item_valid, pop;
  ceat_pkg::result_t res;

  ceat_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .channel_i   (channel_i),
    .condition_i (condition_i),
    .value_i     (value_i),
    .alarm_high_i(alarm_high_i),
    .alarm_low_i (alarm_low_i),
    .range_high_i(range_high_i),
    .range_low_i (range_low_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .pop_i       (pop)
  );

  ceat_back #(.CHANNELS(CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign action_o         = res.action;
  assign event_channel_o  = res.channel;
  assign alarm_kind_o     = res.kind;
  assign event_value_o    = res.value;
  assign acked_now_o      = res.acked_now;
  assign active_alarms_o  = res.active;
  assign unacked_alarms_o = res.unacked;
  assign last_o           = res.last;

endmodule
`default_nettype wire
